>>> src/assert_macros.svh
// Assertion macros for the note priority stack unit.
// Needs a clk_i clock and an active-low rst_ni reset in the including module.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Concurrent assertion clocked on clk_i, idle while reset is asserted.
`define MNPS_ASSERT(label, prop, msg) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (prop)) \
    else $error(msg);

// Implication form: when the condition holds, the consequence holds in the same cycle.
`define MNPS_ASSERT_IMPL(label, cond, cons, msg) \
  `MNPS_ASSERT(label, (cond) |-> (cons), msg)

`endif

>>> src/mnps_pkg.sv
// Types and constants for the monophonic note priority stack.
// No dependencies; used by mnps_cell and mono_note_priority_stack_unit.
`timescale 1ns / 1ps

package mnps_pkg;

  localparam int unsigned NOTE_W   = 7;
  localparam int unsigned PITCH_W  = 16;
  localparam int unsigned VEL_W    = 16;
  localparam int unsigned HELD_W   = 5;
  localparam int unsigned BIT_IDX_W = 3;

  // Event kinds carried in the input tuser bit.
  localparam logic CMD_NOTE_ON  = 1'b0;
  localparam logic CMD_NOTE_OFF = 1'b1;

  // Priority modes.
  localparam logic MODE_LAST    = 1'b0;
  localparam logic MODE_HIGHEST = 1'b1;

  // Register select bit of paddr (word address of register 0).
  localparam logic REG_PRIORITY_MODE = 1'b0;

  localparam logic [BIT_IDX_W-1:0] NOTE_MSB = BIT_IDX_W'(NOTE_W - 1);

  typedef struct packed {
    logic [NOTE_W-1:0]  note;
    logic [PITCH_W-1:0] pitch;
    logic [VEL_W-1:0]   vel;
  } entry_t;

  // Control broadcast from the sequencer to every cell.
  typedef struct packed {
    logic                 upd;
    logic                 note_on;
    logic                 scan_init;
    logic                 scan;
    logic                 any_set;
    logic [BIT_IDX_W-1:0] bit_idx;
    logic                 mode;
  } cell_ctl_t;

  typedef enum logic [3:0] {
    ST_IDLE = 4'b0001,
    ST_UPD  = 4'b0010,
    ST_SCAN = 4'b0100,
    ST_PICK = 4'b1000
  } state_e;

endpackage

>>> src/mnps_cell.sv
// One slot of the note stack: holds an entry, shifts down from its upper
// neighbor, takes appended notes and keeps a candidate bit for the max search. Uses mnps_pkg.
`timescale 1ns / 1ps

module mnps_cell (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  mnps_pkg::cell_ctl_t   ctl_i,
  input  mnps_pkg::entry_t      cmd_i,
  input  logic                  shift_i,
  input  logic                  up_valid_i,
  input  mnps_pkg::entry_t      up_entry_i,
  input  logic                  prev_vafter_i,
  output logic                  valid_o,
  output mnps_pkg::entry_t      entry_o,
  output logic                  hit_o,
  output logic                  vafter_o,
  output logic                  cand_bit_o,
  output logic                  sel_o
);

  logic             valid_q, valid_d;
  logic             cand_q, cand_d;
  mnps_pkg::entry_t entry_q, entry_d;
  logic             append;

  assign hit_o      = valid_q && (entry_q.note == cmd_i.note);
  // Occupancy of this slot once the gap left by a removed note is closed.
  assign vafter_o   = shift_i ? up_valid_i : valid_q;
  assign append     = ctl_i.note_on && !vafter_o && prev_vafter_i;
  assign cand_bit_o = cand_q && valid_q && entry_q.note[ctl_i.bit_idx];
  assign sel_o      = (ctl_i.mode == mnps_pkg::MODE_HIGHEST) ? (cand_q && valid_q)
                                                             : (valid_q && !up_valid_i);
  assign valid_o    = valid_q;
  assign entry_o    = entry_q;

  always_comb begin
    valid_d = valid_q;
    entry_d = entry_q;
    cand_d  = cand_q;
    if (ctl_i.upd) begin
      if (shift_i) begin
        valid_d = up_valid_i;
        entry_d = up_entry_i;
      end
      if (append) begin
        valid_d = 1'b1;
        entry_d = cmd_i;
      end
    end
    if (ctl_i.scan_init) begin
      cand_d = 1'b1;
    end else if (ctl_i.scan) begin
      // Keep only entries whose note has this bit set, when any candidate has it.
      cand_d = cand_q && valid_q && (!ctl_i.any_set || entry_q.note[ctl_i.bit_idx]);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
      cand_q  <= 1'b0;
    end else begin
      valid_q <= valid_d;
      cand_q  <= cand_d;
    end
  end

  always_ff @(posedge clk_i) begin
    entry_q <= entry_d;
  end

endmodule

>>> src/mono_note_priority_stack_unit.sv
// Monophonic note priority stack: a row of mnps_cell slots and the event sequencer.
// Depends on mnps_pkg, mnps_cell and assert_macros.svh.
//
// Each note event word passes through accept, stack update and winner pick in
// last-note mode; in highest-note mode a scan state between update and pick
// resolves the highest note one note bit at a time across the cell row.
// The result word sits in an output register, so the next event word is taken
// while a result still waits. The stack holds MAX_NOTES entries in press order;
// priority_mode lies at byte address 0 of the register port.
`timescale 1ns / 1ps
`include "assert_macros.svh"

module mono_note_priority_stack_unit #(
  parameter int unsigned MAX_NOTES = 16
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  // tdata: note_number[6:0], pitch[22:7], velocity[38:23], zero fill[39]
  input  logic [39:0] s_axis_tdata_i,
  // tuser: func (0 = note on, 1 = note off)
  input  logic        s_axis_tuser_i,
  input  logic        s_axis_tvalid_i,
  output logic        s_axis_tready_o,
  // tdata: win_note[6:0], win_pitch[22:7], win_velocity[38:23],
  //        held_count[43:39], zero fill[47:44]
  output logic [47:0] m_axis_tdata_o,
  // tuser: sounding
  output logic        m_axis_tuser_o,
  output logic        m_axis_tvalid_o,
  input  logic        m_axis_tready_i,
  input  logic        psel_i,
  input  logic        penable_i,
  input  logic        pwrite_i,
  input  logic [2:0]  paddr_i,
  input  logic [31:0] pwdata_i,
  output logic [31:0] prdata_o,
  output logic        pready_o
);

  localparam int unsigned CW = $clog2(MAX_NOTES + 1);

  mnps_pkg::state_e    state_q, state_d;
  mnps_pkg::entry_t    cmd_q;
  logic                cmd_off_q;
  logic                mode_q;
  logic [mnps_pkg::BIT_IDX_W-1:0] bit_q;
  logic [CW-1:0]       count_q;
  logic                out_valid_q;
  logic [47:0]         out_data_q;
  logic                out_user_q;

  mnps_pkg::cell_ctl_t ctl;
  mnps_pkg::entry_t    entry_vec [MAX_NOTES];
  logic [MAX_NOTES-1:0] valid_vec, hit_vec, shift_vec, vafter_vec, cand_vec, sel_vec;
  logic                 append_any;
  mnps_pkg::entry_t     win;
  logic [CW+4:0]        count_ext;
  logic                 in_acc, out_free;

  assign s_axis_tready_o = (state_q == mnps_pkg::ST_IDLE);
  assign in_acc          = s_axis_tvalid_i && s_axis_tready_o;
  assign out_free        = !out_valid_q || m_axis_tready_i;

  // Register port.
  assign pready_o = 1'b1;
  assign prdata_o = (paddr_i[2] == mnps_pkg::REG_PRIORITY_MODE) ? {31'b0, mode_q} : 32'b0;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      mode_q <= mnps_pkg::MODE_LAST;
    end else if (psel_i && penable_i && pwrite_i && pready_o &&
                 paddr_i[2] == mnps_pkg::REG_PRIORITY_MODE) begin
      mode_q <= pwdata_i[0];
    end
  end

  always_comb begin
    ctl.upd       = (state_q == mnps_pkg::ST_UPD);
    ctl.note_on   = (state_q == mnps_pkg::ST_UPD) && (cmd_off_q == mnps_pkg::CMD_NOTE_ON);
    ctl.scan_init = (state_q == mnps_pkg::ST_UPD);
    ctl.scan      = (state_q == mnps_pkg::ST_SCAN);
    ctl.any_set   = |cand_vec;
    ctl.bit_idx   = bit_q;
    ctl.mode      = mode_q;
  end

  // Cell row. Held notes are unique, so at most one cell matches and the
  // highest-note search ends with exactly one candidate.
  for (genvar i = 0; i < MAX_NOTES; i++) begin : g_cell
    logic             up_valid;
    mnps_pkg::entry_t up_entry;
    logic             prev_vafter;

    assign shift_vec[i] = |hit_vec[i:0];
    if (i == MAX_NOTES - 1) begin : g_top
      assign up_valid = 1'b0;
      assign up_entry = entry_vec[i];
    end else begin : g_mid
      assign up_valid = valid_vec[i+1];
      assign up_entry = entry_vec[i+1];
    end
    if (i == 0) begin : g_bottom
      assign prev_vafter = 1'b1;
    end else begin : g_upper
      assign prev_vafter = vafter_vec[i-1];
    end

    mnps_cell u_cell (
      .clk_i         (clk_i),
      .rst_ni        (rst_ni),
      .ctl_i         (ctl),
      .cmd_i         (cmd_q),
      .shift_i       (shift_vec[i]),
      .up_valid_i    (up_valid),
      .up_entry_i    (up_entry),
      .prev_vafter_i (prev_vafter),
      .valid_o       (valid_vec[i]),
      .entry_o       (entry_vec[i]),
      .hit_o         (hit_vec[i]),
      .vafter_o      (vafter_vec[i]),
      .cand_bit_o    (cand_vec[i]),
      .sel_o         (sel_vec[i])
    );
  end

  assign append_any = (cmd_off_q == mnps_pkg::CMD_NOTE_ON) && !vafter_vec[MAX_NOTES-1];

  always_comb begin
    win = '0;
    for (int i = 0; i < MAX_NOTES; i++) begin
      win = win | (sel_vec[i] ? entry_vec[i] : '0);
    end
  end

  assign count_ext = {5'b0, count_q};

  always_comb begin
    state_d = state_q;
    unique case (state_q)
      mnps_pkg::ST_IDLE: if (in_acc) state_d = mnps_pkg::ST_UPD;
      mnps_pkg::ST_UPD:  state_d = (mode_q == mnps_pkg::MODE_HIGHEST) ? mnps_pkg::ST_SCAN
                                                                     : mnps_pkg::ST_PICK;
      mnps_pkg::ST_SCAN: if (bit_q == '0) state_d = mnps_pkg::ST_PICK;
      mnps_pkg::ST_PICK: if (out_free) state_d = mnps_pkg::ST_IDLE;
      default:           state_d = mnps_pkg::ST_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= mnps_pkg::ST_IDLE;
      count_q     <= '0;
      bit_q       <= '0;
      out_valid_q <= 1'b0;
    end else begin
      state_q <= state_d;
      if (state_q == mnps_pkg::ST_UPD) begin
        count_q <= count_q - CW'(shift_vec[MAX_NOTES-1]) + CW'(append_any);
        bit_q   <= mnps_pkg::NOTE_MSB;
      end else if (state_q == mnps_pkg::ST_SCAN) begin
        bit_q <= bit_q - 1'b1;
      end
      if (state_q == mnps_pkg::ST_PICK && out_free) begin
        out_valid_q <= 1'b1;
      end else if (m_axis_tready_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_acc) begin
      cmd_q.note  <= s_axis_tdata_i[6:0];
      cmd_q.pitch <= s_axis_tdata_i[22:7];
      cmd_q.vel   <= s_axis_tdata_i[38:23];
      cmd_off_q   <= s_axis_tuser_i;
    end
    if (state_q == mnps_pkg::ST_PICK && out_free) begin
      out_data_q <= {4'b0, count_ext[4:0], win.vel, win.pitch, win.note};
      out_user_q <= valid_vec[0];
    end
  end

  assign m_axis_tvalid_o = out_valid_q;
  assign m_axis_tdata_o  = out_data_q;
  assign m_axis_tuser_o  = out_user_q;

  // Held entries always fill the bottom of the row without gaps.
  `MNPS_ASSERT(a_valid_packed, ((valid_vec & (valid_vec + 1'b1)) == '0), "stack has a gap")
  `MNPS_ASSERT(a_count_match, (32'(count_q) == $countones(valid_vec)), "count out of step")
  `MNPS_ASSERT_IMPL(a_one_winner, (state_q == mnps_pkg::ST_PICK && valid_vec[0]), $onehot(sel_vec), "winner select not one-hot")
  `MNPS_ASSERT_IMPL(a_silent_empty, (state_q == mnps_pkg::ST_PICK && !valid_vec[0]), (sel_vec == '0), "winner selected in empty stack")

endmodule

>>> sim/mono_note_priority_stack_unit_tb.sv
`timescale 1ns / 1ps
// Testbench for mono_note_priority_stack_unit: directed and random note events
// in both priority modes, each result word checked against a held-note stack.
// Depends on mnps_pkg and the mono_note_priority_stack_unit RTL.

module mono_note_priority_stack_unit_tb;

  localparam int unsigned STACK_DEPTH  = 16;
  localparam int unsigned CYCLE_LIMIT  = 400000;
  localparam int unsigned PHASES       = 8;
  localparam int unsigned PHASE_EVENTS = 75;
  localparam logic [2:0]  ADDR_PRIORITY_MODE = 3'd0;
  localparam logic [2:0]  ADDR_NO_REG        = 3'd4;

  typedef struct packed {
    logic                         sounding;
    logic [mnps_pkg::NOTE_W-1:0]  note;
    logic [mnps_pkg::PITCH_W-1:0] pitch;
    logic [mnps_pkg::VEL_W-1:0]   vel;
    logic [mnps_pkg::HELD_W-1:0]  held;
  } winner_t;

  // Tracks the held notes in press order and the winner words still owed.
  class held_note_stack;
    mnps_pkg::entry_t slots[STACK_DEPTH];
    int unsigned      count;
    logic             mode;
    winner_t          winners_due[$];
    int unsigned      mismatches;

    function void set_mode(logic m);
      mode = m;
    endfunction

    function void flag(string what, logic [63:0] want, logic [63:0] got);
      mismatches++;
      if (mismatches <= 10) begin
        $display("mismatch: %s expected %0h got %0h", what, want, got);
      end
    endfunction

    function void take_event(logic func, logic [mnps_pkg::NOTE_W-1:0] note_num,
                             logic [mnps_pkg::PITCH_W-1:0] pitch_in,
                             logic [mnps_pkg::VEL_W-1:0] vel_in);
      int unsigned pos;
      int unsigned top;
      winner_t     w;
      pos = count;
      for (int unsigned i = 0; i < count; i++) begin
        if (pos == count && slots[i].note == note_num) pos = i;
      end
      // A held copy of the note is removed first, keeping press order.
      if (pos < count) begin
        for (int unsigned j = pos; j + 1 < count; j++) slots[j] = slots[j + 1];
        count--;
      end
      if (func == mnps_pkg::CMD_NOTE_ON && count < STACK_DEPTH) begin
        slots[count].note  = note_num;
        slots[count].pitch = pitch_in;
        slots[count].vel   = vel_in;
        count++;
      end
      w = '0;
      if (count != 0) begin
        top = count - 1;
        if (mode == mnps_pkg::MODE_HIGHEST) begin
          // Strict compare, so a tie stays with the earliest entry.
          top = 0;
          for (int unsigned i = 1; i < count; i++) begin
            if (slots[i].note > slots[top].note) top = i;
          end
        end
        w.sounding = 1'b1;
        w.note     = slots[top].note;
        w.pitch    = slots[top].pitch;
        w.vel      = slots[top].vel;
        w.held     = mnps_pkg::HELD_W'(count);
      end
      winners_due.push_back(w);
    endfunction

    function void match_winner(winner_t got);
      winner_t want;
      if (winners_due.size() == 0) begin
        flag("result word with none due", '0, got);
        return;
      end
      want = winners_due.pop_front();
      if (got.sounding != want.sounding) flag("sounding", want.sounding, got.sounding);
      if (got.note != want.note) flag("win_note", want.note, got.note);
      if (got.pitch != want.pitch) flag("win_pitch", want.pitch, got.pitch);
      if (got.vel != want.vel) flag("win_velocity", want.vel, got.vel);
      if (got.held != want.held) flag("held_count", want.held, got.held);
    endfunction
  endclass

  logic        clk_i;
  logic        rst_ni;
  logic [39:0] s_axis_tdata_i;
  logic        s_axis_tuser_i;
  logic        s_axis_tvalid_i;
  logic        s_axis_tready_o;
  logic [47:0] m_axis_tdata_o;
  logic        m_axis_tuser_o;
  logic        m_axis_tvalid_o;
  logic        m_axis_tready_i = 1'b0;
  logic        psel_i;
  logic        penable_i;
  logic        pwrite_i;
  logic [2:0]  paddr_i;
  logic [31:0] pwdata_i;
  logic [31:0] prdata_o;
  logic        pready_o;

  held_note_stack stack = new();
  int unsigned    cycles;
  int unsigned    rx_left;
  int unsigned    burst_left;

  mono_note_priority_stack_unit #(
    .MAX_NOTES(STACK_DEPTH)
  ) dut (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .s_axis_tdata_i (s_axis_tdata_i),
    .s_axis_tuser_i (s_axis_tuser_i),
    .s_axis_tvalid_i(s_axis_tvalid_i),
    .s_axis_tready_o(s_axis_tready_o),
    .m_axis_tdata_o (m_axis_tdata_o),
    .m_axis_tuser_o (m_axis_tuser_o),
    .m_axis_tvalid_o(m_axis_tvalid_o),
    .m_axis_tready_i(m_axis_tready_i),
    .psel_i         (psel_i),
    .penable_i      (penable_i),
    .pwrite_i       (pwrite_i),
    .paddr_i        (paddr_i),
    .pwdata_i       (pwdata_i),
    .prdata_o       (prdata_o),
    .pready_o       (pready_o)
  );

  always #5 clk_i = ~clk_i;

  always @(posedge clk_i) begin
    cycles++;
    if (cycles > CYCLE_LIMIT) begin
      $display("tb: failure");
      $finish;
    end
  end

  // Result words: win_note, win_pitch, win_velocity, held_count from bit 0 up.
  always @(posedge clk_i) begin
    if (rst_ni && m_axis_tvalid_o && m_axis_tready_i) begin
      stack.match_winner({m_axis_tuser_o, m_axis_tdata_o[6:0], m_axis_tdata_o[22:7],
                          m_axis_tdata_o[38:23], m_axis_tdata_o[43:39]});
    end
  end

  // Receiver: short and long stalls, with long stretches of steady ready.
  always @(negedge clk_i) begin
    if (rx_left == 0) begin
      if (m_axis_tready_i) begin
        m_axis_tready_i = 1'b0;
        rx_left = ($urandom_range(0, 7) == 0) ? $urandom_range(8, 16) : $urandom_range(1, 4);
      end else begin
        m_axis_tready_i = 1'b1;
        rx_left = ($urandom_range(0, 5) == 0) ? $urandom_range(30, 80) : $urandom_range(1, 8);
      end
    end else begin
      rx_left--;
    end
  end

  task automatic send_event(input logic func, input logic [mnps_pkg::NOTE_W-1:0] note_num,
                            input logic [mnps_pkg::PITCH_W-1:0] pitch_in,
                            input logic [mnps_pkg::VEL_W-1:0] vel_in);
    s_axis_tuser_i  = func;
    s_axis_tdata_i  = {1'b0, vel_in, pitch_in, note_num};
    s_axis_tvalid_i = 1'b1;
    @(posedge clk_i);
    while (!s_axis_tready_o) @(posedge clk_i);
    stack.take_event(func, note_num, pitch_in, vel_in);
    @(negedge clk_i);
  endtask

  // Sender pacing: bursts of random length separated by random gaps.
  task automatic pace();
    if (burst_left == 0) begin
      s_axis_tvalid_i = 1'b0;
      repeat ($urandom_range(1, 10)) @(negedge clk_i);
      burst_left = ($urandom_range(0, 7) == 0) ? 60 : $urandom_range(1, 24);
    end else begin
      burst_left--;
    end
  endtask

  task automatic wait_drained();
    s_axis_tvalid_i = 1'b0;
    while (stack.winners_due.size() != 0) @(negedge clk_i);
    repeat (4) @(negedge clk_i);
  endtask

  task automatic reg_access(input logic wr, input logic [2:0] addr, input logic [31:0] data);
    psel_i    = 1'b1;
    penable_i = 1'b0;
    pwrite_i  = wr;
    paddr_i   = addr;
    pwdata_i  = data;
    @(negedge clk_i);
    penable_i = 1'b1;
    @(posedge clk_i);
    while (!pready_o) @(posedge clk_i);
    if (wr && addr == ADDR_PRIORITY_MODE) stack.set_mode(data[0]);
    if (!wr && prdata_o !== {31'b0, stack.mode}) begin
      stack.flag("priority_mode readback", {31'b0, stack.mode}, prdata_o);
    end
    @(negedge clk_i);
    psel_i    = 1'b0;
    penable_i = 1'b0;
    pwrite_i  = 1'b0;
  endtask

  task automatic set_mode_reg(input logic [2:0] addr, input logic m);
    reg_access(1'b1, addr, ($urandom & 32'hFFFF_FFFE) | {31'b0, m});
    reg_access(1'b0, ADDR_PRIORITY_MODE, '0);
  endtask

  initial begin
    logic [mnps_pkg::NOTE_W-1:0] pool[40];
    logic                        phase_mode[PHASES];
    int unsigned                 pool_size;
    int unsigned                 on_pct;
    logic [mnps_pkg::NOTE_W-1:0] pick;
    logic                        func;

    clk_i           = 1'b0;
    rst_ni          = 1'b0;
    s_axis_tdata_i  = '0;
    s_axis_tuser_i  = mnps_pkg::CMD_NOTE_ON;
    s_axis_tvalid_i = 1'b0;
    psel_i          = 1'b0;
    penable_i       = 1'b0;
    pwrite_i        = 1'b0;
    paddr_i         = '0;
    pwdata_i        = '0;
    stack.set_mode(mnps_pkg::MODE_LAST);
    repeat (12) @(negedge clk_i);
    rst_ni = 1'b1;
    @(negedge clk_i);

    // Directed: extremes, re-press of a held note, stray note-off, empty stack.
    send_event(mnps_pkg::CMD_NOTE_ON, 7'd0, 16'h0000, 16'h0000);
    send_event(mnps_pkg::CMD_NOTE_ON, 7'd127, 16'hFFFF, 16'hFFFF);
    send_event(mnps_pkg::CMD_NOTE_OFF, 7'd55, 16'hFFFF, 16'hFFFF);
    send_event(mnps_pkg::CMD_NOTE_ON, 7'd0, 16'h1234, 16'h8000);
    send_event(mnps_pkg::CMD_NOTE_OFF, 7'd127, 16'h0000, 16'h0000);
    send_event(mnps_pkg::CMD_NOTE_OFF, 7'd0, 16'h0000, 16'h0000);
    send_event(mnps_pkg::CMD_NOTE_OFF, 7'd0, 16'hFFFF, 16'hFFFF);
    // Fill the stack, then press a new note (dropped) and a held one (moved up).
    for (int unsigned i = 0; i < STACK_DEPTH; i++) begin
      send_event(mnps_pkg::CMD_NOTE_ON, mnps_pkg::NOTE_W'(i * 7 + 3),
                 mnps_pkg::PITCH_W'($urandom), mnps_pkg::VEL_W'($urandom));
    end
    send_event(mnps_pkg::CMD_NOTE_ON, 7'd120, 16'hABCD, 16'h4321);
    send_event(mnps_pkg::CMD_NOTE_ON, 7'd38, 16'h5555, 16'hAAAA);
    wait_drained();

    phase_mode = '{mnps_pkg::MODE_HIGHEST, mnps_pkg::MODE_LAST, mnps_pkg::MODE_HIGHEST,
                   mnps_pkg::MODE_HIGHEST, mnps_pkg::MODE_LAST, mnps_pkg::MODE_HIGHEST,
                   mnps_pkg::MODE_LAST, mnps_pkg::MODE_HIGHEST};
    for (int unsigned ph = 0; ph < PHASES; ph++) begin
      set_mode_reg(ADDR_PRIORITY_MODE, phase_mode[ph]);
      // A write to an address with no register must leave the mode alone.
      if (ph == 3) set_mode_reg(ADDR_NO_REG, ~phase_mode[ph]);
      pool_size = $urandom_range(4, 40);
      on_pct    = $urandom_range(25, 85);
      for (int unsigned i = 0; i < pool_size; i++) pool[i] = mnps_pkg::NOTE_W'($urandom);
      for (int unsigned k = 0; k < PHASE_EVENTS; k++) begin
        pace();
        if ($urandom_range(0, 99) < 10) pick = mnps_pkg::NOTE_W'($urandom);
        else pick = pool[$urandom_range(0, pool_size - 1)];
        func = ($urandom_range(0, 99) < on_pct) ? mnps_pkg::CMD_NOTE_ON
                                                : mnps_pkg::CMD_NOTE_OFF;
        send_event(func, pick, mnps_pkg::PITCH_W'($urandom), mnps_pkg::VEL_W'($urandom));
      end
      wait_drained();
    end

    repeat (20) @(negedge clk_i);
    if (stack.mismatches == 0 && stack.winners_due.size() == 0) begin
      $display("tb: success");
    end else begin
      $display("tb: failure");
    end
    $finish;
  end

endmodule
